// ===== design/swdik_pkg.sv =====
// shared widths, constants and helpers for the swerve drive kinematics datapath
package swdik_pkg;

	localparam int CMD_W  = 16;
	localparam int CFG_W  = 16;
	localparam int IDX_W  = 2;
	localparam int SPD_W  = 15;
	localparam int ANG_W  = 16;
	localparam int TW     = 34;
	localparam int RW     = 34;
	localparam int VIN_W  = 35;
	localparam int VW     = 38;
	localparam int ZW     = 34;
	localparam int MW     = 34;
	localparam int NW     = 49;
	localparam int QW     = 15;
	localparam int ARC_LEN = 24;

	localparam logic [IDX_W-1:0] REG_BASE_LEN  = 2'd0;
	localparam logic [IDX_W-1:0] REG_TRACK_LEN = 2'd1;

	localparam logic [CFG_W-1:0] BASE_LEN_RST  = 16'd4096;
	localparam logic [CFG_W-1:0] TRACK_LEN_RST = 16'd4915;

	localparam logic [29:0] KINV_Q30 = 30'd652032874;
	localparam logic signed [ZW-1:0] TURN_QUARTER = 34'sd1073741824;
	localparam logic [MW-1:0] UNIT_Q27 = 34'd134217728;
	localparam logic [SPD_W-1:0] SPD_MAX = 15'd16384;

	localparam logic signed [ZW-1:0] ARC_TAB [ARC_LEN] = '{
		34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
		34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
		34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
		34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
		34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
		34'sd652,       34'sd326,       34'sd163,       34'sd81
	};

	typedef logic signed [TW-1:0]  trig_t;
	typedef logic signed [VIN_W-1:0] vin_t;
	typedef logic [MW-1:0]         mag_t;
	typedef logic signed [ANG_W-1:0] ang_t;
	typedef logic [SPD_W-1:0]      spd_t;

	// clip a speed to 1.0
	function automatic spd_t sat_spd(input logic [21:0] v);
		spd_t r;
		if (v > 22'(SPD_MAX)) r = SPD_MAX;
		else r = v[SPD_W-1:0];
		return r;
	endfunction

endpackage

// ===== design/swdik_sincos.sv =====
// rotation-mode cordic giving cosine and sine of the heading, one iteration per stage
module swdik_sincos #(
	parameter int STAGES = 16,
	parameter int SB_W = 48
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic [swdik_pkg::ANG_W-1:0] heading,
	input  logic [SB_W-1:0] in_sb,
	output logic out_valid,
	output swdik_pkg::trig_t cos_v,
	output swdik_pkg::trig_t sin_v,
	output logic [SB_W-1:0] out_sb
);
	import swdik_pkg::*;

	typedef struct packed {
		logic signed [TW-1:0] x;
		logic signed [TW-1:0] y;
		logic signed [ZW-1:0] z;
		logic flip;
		logic [SB_W-1:0] sb;
	} rot_t;

	rot_t st_s [0:STAGES];
	logic v_s [0:STAGES];
	rot_t prep;
	logic out_v_q;
	trig_t cos_q, sin_q;
	logic [SB_W-1:0] sb_q;

	// left half plane: turn by pi first
	always_comb begin
		logic [31:0] a;
		prep.flip = heading[15] ^ heading[14];
		a = {heading[15] ^ prep.flip, heading[14:0], 16'b0};
		prep.x = TW'(KINV_Q30);
		prep.y = '0;
		prep.z = ZW'($signed(a));
		prep.sb = in_sb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0] <= prep;
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_it
		rot_t nxt;
		always_comb begin
			logic signed [TW-1:0] dx, dy;
			dx = st_s[i].y >>> i;
			dy = st_s[i].x >>> i;
			nxt = st_s[i];
			if (st_s[i].z >= 0) begin
				nxt.x = st_s[i].x - dx;
				nxt.y = st_s[i].y + dy;
				nxt.z = st_s[i].z - ARC_TAB[i];
			end else begin
				nxt.x = st_s[i].x + dx;
				nxt.y = st_s[i].y - dy;
				nxt.z = st_s[i].z + ARC_TAB[i];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				st_s[i+1] <= nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= v_s[STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_q <= st_s[STAGES].flip ? -st_s[STAGES].x : st_s[STAGES].x;
			sin_q <= st_s[STAGES].flip ? -st_s[STAGES].y : st_s[STAGES].y;
			sb_q  <= st_s[STAGES].sb;
		end
	end

	assign out_valid = out_v_q;
	assign cos_v = cos_q;
	assign sin_v = sin_q;
	assign out_sb = sb_q;

endmodule

// ===== design/swdik_polar.sv =====
// four-lane vectoring cordic: magnitude and angle of each module vector
module swdik_polar #(
	parameter int STAGES = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  swdik_pkg::vin_t vx [4],
	input  swdik_pkg::vin_t vy [4],
	output logic out_valid,
	output swdik_pkg::mag_t mag [4],
	output swdik_pkg::ang_t ang [4]
);
	import swdik_pkg::*;

	localparam int SUM_W = 70;

	typedef struct packed {
		logic signed [VW-1:0] x;
		logic signed [VW-1:0] y;
		logic signed [ZW-1:0] z;
		logic zero;
	} vec_t;

	vec_t st_s [0:STAGES][4];
	logic v_s [0:STAGES];
	vec_t prep [4];

	logic m1_v_s, m2_v_s;
	logic [47:0] ppl_s1 [4];
	logic signed [50:0] pph_s1 [4];
	logic signed [ZW-1:0] z_s1 [4];
	logic zero_s1 [4];
	mag_t mag_s2 [4];
	ang_t ang_s2 [4];

	// pre-turn by a quarter when x is negative
	always_comb begin
		for (int l = 0; l < 4; l++) begin
			prep[l].zero = (vx[l] == '0) && (vy[l] == '0);
			prep[l].x = VW'(vx[l]);
			prep[l].y = VW'(vy[l]);
			prep[l].z = '0;
			if (vx[l] < 0) begin
				if (vy[l] >= 0) begin
					prep[l].x = VW'(vy[l]);
					prep[l].y = -VW'(vx[l]);
					prep[l].z = TURN_QUARTER;
				end else begin
					prep[l].x = -VW'(vy[l]);
					prep[l].y = VW'(vx[l]);
					prep[l].z = -TURN_QUARTER;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 4; l++) st_s[0][l] <= prep[l];
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_it
		vec_t nxt [4];
		always_comb begin
			for (int l = 0; l < 4; l++) begin
				nxt[l] = st_s[i][l];
				if (st_s[i][l].y > 0) begin
					nxt[l].x = st_s[i][l].x + (st_s[i][l].y >>> i);
					nxt[l].y = st_s[i][l].y - (st_s[i][l].x >>> i);
					nxt[l].z = st_s[i][l].z + ARC_TAB[i];
				end else begin
					nxt[l].x = st_s[i][l].x - (st_s[i][l].y >>> i);
					nxt[l].y = st_s[i][l].y + (st_s[i][l].x >>> i);
					nxt[l].z = st_s[i][l].z - ARC_TAB[i];
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < 4; l++) st_s[i+1][l] <= nxt[l];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m1_v_s <= 1'b0;
			m2_v_s <= 1'b0;
		end else if (en) begin
			m1_v_s <= v_s[STAGES];
			m2_v_s <= m1_v_s;
		end
	end

	// gain correction split into two partial products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 4; l++) begin
				ppl_s1[l]  <= 48'(st_s[STAGES][l].x[17:0]) * 48'(KINV_Q30);
				pph_s1[l]  <= 51'($signed(st_s[STAGES][l].x[VW-1:18]))
					* 51'($signed({1'b0, KINV_Q30}));
				z_s1[l]    <= st_s[STAGES][l].z;
				zero_s1[l] <= st_s[STAGES][l].zero;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 4; l++) begin
				logic signed [SUM_W-1:0] sum;
				logic signed [ZW-1:0] zr;
				sum = (SUM_W'(pph_s1[l]) <<< 18) + $signed(SUM_W'(ppl_s1[l]))
					+ $signed(SUM_W'(1) << 29);
				zr = z_s1[l] + ZW'(32768);
				mag_s2[l] <= sum[SUM_W-1] ? '0 : sum[30 +: MW];
				ang_s2[l] <= zero_s1[l] ? '0 : zr[31:16];
			end
		end
	end

	assign out_valid = m2_v_s;
	assign mag = mag_s2;
	assign ang = ang_s2;

endmodule

// ===== design/swdik_div.sv =====
// four-lane restoring divider with a shared divisor, one quotient bit per stage
module swdik_div #(
	parameter int SB_W = 125
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic [3:0][swdik_pkg::NW-1:0] num,
	input  swdik_pkg::mag_t den,
	input  logic [SB_W-1:0] in_sb,
	output logic out_valid,
	output logic [3:0][swdik_pkg::QW-1:0] quo,
	output logic [SB_W-1:0] out_sb
);
	import swdik_pkg::*;

	typedef struct packed {
		logic [3:0][NW-1:0] r;
		logic [3:0][QW-1:0] q;
		logic [MW-1:0] d;
		logic [SB_W-1:0] sb;
	} div_t;

	div_t st_s [0:QW];
	logic v_s [0:QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0].r  <= num;
			st_s[0].q  <= '0;
			st_s[0].d  <= den;
			st_s[0].sb <= in_sb;
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_bit
		localparam int B = QW - 1 - k;
		div_t nxt;
		always_comb begin
			logic [NW-1:0] dsh;
			dsh = NW'(st_s[k].d) << B;
			nxt = st_s[k];
			for (int l = 0; l < 4; l++) begin
				if (st_s[k].r[l] >= dsh) begin
					nxt.r[l] = st_s[k].r[l] - dsh;
					nxt.q[l][B] = 1'b1;
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				st_s[k+1] <= nxt;
			end
		end
	end

	assign out_valid = v_s[QW];
	assign quo = st_s[QW].q;
	assign out_sb = st_s[QW].sb;

endmodule

// ===== design/swerve_drive_inverse_kinematics.sv =====
// top level: field-oriented swerve drive inverse kinematics pipeline
// A fully pipelined datapath that takes one drive command beat per clock while in_stall is low
// and gives one result beat per command, in order. It is made up of a sine/cosine cordic of
// CORDIC_STAGES + 2 stages, three stages of field-to-robot rotation and vector forming, a
// four-lane vectoring cordic of CORDIC_STAGES + 3 stages, two stages of peak search, a 16-stage
// divider for speed normalisation and one output register. Throughput is one beat per cycle
// if not stalled, set by the one-iteration-per-stage cordics and one-bit-per-stage divider.
// The output register plus a skid register decouple the two channels, so in_stall rises only
// once both are full. Configuration writes take effect at once and should be made while idle.
module swerve_drive_inverse_kinematics #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic clk,
	input  logic arst_n,

	// configuration write port
	input  logic cfg_wr_en,
	input  logic [swdik_pkg::IDX_W-1:0] cfg_index,
	input  logic [swdik_pkg::CFG_W-1:0] cfg_data,

	// command channel
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [swdik_pkg::CMD_W-1:0] forward_cmd,
	input  logic signed [swdik_pkg::CMD_W-1:0] strafe_cmd,
	input  logic signed [swdik_pkg::CMD_W-1:0] rotate_cmd,
	input  logic [swdik_pkg::ANG_W-1:0] heading_angle,

	// result channel
	output logic out_valid,
	input  logic out_stall,
	output logic [swdik_pkg::SPD_W-1:0] front_right_speed,
	output logic [swdik_pkg::SPD_W-1:0] front_left_speed,
	output logic [swdik_pkg::SPD_W-1:0] back_left_speed,
	output logic [swdik_pkg::SPD_W-1:0] back_right_speed,
	output logic signed [swdik_pkg::ANG_W-1:0] front_right_angle,
	output logic signed [swdik_pkg::ANG_W-1:0] front_left_angle,
	output logic signed [swdik_pkg::ANG_W-1:0] back_left_angle,
	output logic signed [swdik_pkg::ANG_W-1:0] back_right_angle
);
	import swdik_pkg::*;

	typedef struct packed {
		logic signed [CMD_W-1:0] fwd;
		logic signed [CMD_W-1:0] str;
		logic signed [CMD_W-1:0] rot;
	} cmd_t;

	typedef struct packed {
		logic [3:0][ANG_W-1:0] ang;
		logic [3:0][SPD_W-1:0] dflt;
		logic norm;
	} dsb_t;

	typedef struct packed {
		logic [3:0][SPD_W-1:0] spd;
		logic [3:0][ANG_W-1:0] ang;
	} res_t;

	// configuration registers
	logic [CFG_W-1:0] base_len_q, track_len_q;

	// pipeline advance: held only while the skid register is occupied
	logic en;

	// sine/cosine
	cmd_t cmd_in, cmd_sc;
	logic sc_v;
	trig_t cos_v, sin_v;

	// rotation and vector forming
	logic v_s1, v_s2, v_s3;
	logic signed [49:0] pfc_s1, psc_s1, pvc_s1, pfs_s1;
	logic signed [32:0] rl_s1, rw_s1, rl_s2, rw_s2;
	logic signed [RW-1:0] rf_s2, rs_s2;
	vin_t vx_s3 [4];
	vin_t vy_s3 [4];

	// polar
	logic pol_v;
	mag_t pol_mag [4];
	ang_t pol_ang [4];

	// peak search
	logic v_s4, v_s5;
	mag_t mag_s4 [4];
	ang_t ang_s4 [4];
	mag_t m01_s4, m23_s4, peak_s5;
	logic [3:0][NW-1:0] num_s5;
	dsb_t dsb_s5;

	// divider
	logic dv_v;
	logic [3:0][QW-1:0] dv_q;
	dsb_t dv_sb;
	res_t res;

	// output register and skid register
	logic out_v_q, skid_v_q;
	res_t out_q, skid_q;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_len_q  <= BASE_LEN_RST;
			track_len_q <= TRACK_LEN_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_BASE_LEN:  base_len_q  <= cfg_data;
				REG_TRACK_LEN: track_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en = !skid_v_q;
	assign in_stall = skid_v_q;

	// ---------------- heading sine and cosine ----------------
	assign cmd_in = '{fwd: forward_cmd, str: strafe_cmd, rot: rotate_cmd};

	swdik_sincos #(
		.STAGES(CORDIC_STAGES),
		.SB_W($bits(cmd_t))
	) u_sincos (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(in_valid),
		.heading(heading_angle),
		.in_sb(cmd_in),
		.out_valid(sc_v),
		.cos_v(cos_v),
		.sin_v(sin_v),
		.out_sb(cmd_sc)
	);

	// ---------------- field to robot frame ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= sc_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1: products; r*L and r*W are exact in Q27
	always_ff @(posedge clk) begin
		if (en) begin
			pfc_s1 <= 50'(cmd_sc.fwd) * 50'(cos_v);
			psc_s1 <= 50'(cmd_sc.str) * 50'(sin_v);
			pvc_s1 <= 50'(cmd_sc.str) * 50'(cos_v);
			pfs_s1 <= 50'(cmd_sc.fwd) * 50'(sin_v);
			rl_s1  <= 33'(cmd_sc.rot) * 33'($signed({1'b0, base_len_q}));
			rw_s1  <= 33'(cmd_sc.rot) * 33'($signed({1'b0, track_len_q}));
		end
	end

	// stage 2: Q44 sums rounded half up into Q27
	always_ff @(posedge clk) begin
		if (en) begin
			logic signed [50:0] sf, ss;
			sf = 51'(pfc_s1) + 51'(psc_s1) + 51'sd65536;
			ss = 51'(pvc_s1) - 51'(pfs_s1) + 51'sd65536;
			rf_s2 <= sf[17 +: RW];
			rs_s2 <= ss[17 +: RW];
			rl_s2 <= rl_s1;
			rw_s2 <= rw_s1;
		end
	end

	// stage 3: module vectors, lanes in order front right, front left, back left, back right
	always_ff @(posedge clk) begin
		if (en) begin
			logic signed [VIN_W-1:0] back, front, left, right;
			back  = VIN_W'(rs_s2) - VIN_W'(rl_s2);
			front = VIN_W'(rs_s2) + VIN_W'(rl_s2);
			left  = VIN_W'(rf_s2) - VIN_W'(rw_s2);
			right = VIN_W'(rf_s2) + VIN_W'(rw_s2);
			vx_s3[0] <= right;
			vy_s3[0] <= front;
			vx_s3[1] <= left;
			vy_s3[1] <= front;
			vx_s3[2] <= left;
			vy_s3[2] <= back;
			vx_s3[3] <= right;
			vy_s3[3] <= back;
		end
	end

	// ---------------- magnitude and steering angle ----------------
	swdik_polar #(
		.STAGES(CORDIC_STAGES)
	) u_polar (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(v_s3),
		.vx(vx_s3),
		.vy(vy_s3),
		.out_valid(pol_v),
		.mag(pol_mag),
		.ang(pol_ang)
	);

	// ---------------- peak speed ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s4 <= pol_v;
			v_s5 <= v_s4;
		end
	end

	// pairwise maxima
	always_ff @(posedge clk) begin
		if (en) begin
			m01_s4 <= (pol_mag[1] > pol_mag[0]) ? pol_mag[1] : pol_mag[0];
			m23_s4 <= (pol_mag[3] > pol_mag[2]) ? pol_mag[3] : pol_mag[2];
			mag_s4 <= pol_mag;
			ang_s4 <= pol_ang;
		end
	end

	// overall peak, divider numerators and the plain Q27 to Q14 rounding
	always_ff @(posedge clk) begin
		if (en) begin
			mag_t pk;
			pk = (m23_s4 > m01_s4) ? m23_s4 : m01_s4;
			peak_s5 <= pk;
			dsb_s5.norm <= pk > UNIT_Q27;
			for (int l = 0; l < 4; l++) begin
				logic [MW:0] rnd;
				rnd = (MW+1)'(mag_s4[l]) + (MW+1)'(4096);
				num_s5[l] <= NW'({mag_s4[l], 14'b0}) + NW'(pk >> 1);
				dsb_s5.dflt[l] <= sat_spd(rnd[13 +: 22]);
				dsb_s5.ang[l] <= ang_s4[l];
			end
		end
	end

	// ---------------- normalisation ----------------
	swdik_div #(
		.SB_W($bits(dsb_t))
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(v_s5),
		.num(num_s5),
		.den(peak_s5),
		.in_sb(dsb_s5),
		.out_valid(dv_v),
		.quo(dv_q),
		.out_sb(dv_sb)
	);

	// divided speeds only when the peak is above 1.0
	always_comb begin
		for (int l = 0; l < 4; l++) begin
			res.spd[l] = dv_sb.norm ? sat_spd(22'(dv_q[l])) : dv_sb.dflt[l];
			res.ang[l] = dv_sb.ang[l];
		end
	end

	// ---------------- output register and skid ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			// pipeline frozen, drain the skid beat once the output moves
			if (!out_stall) skid_v_q <= 1'b0;
		end else if (dv_v) begin
			if (out_v_q && out_stall) skid_v_q <= 1'b1;
			else out_v_q <= 1'b1;
		end else if (!out_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (!out_stall) out_q <= skid_q;
		end else if (dv_v) begin
			if (out_v_q && out_stall) skid_q <= res;
			else out_q <= res;
		end
	end

	assign out_valid = out_v_q;
	assign front_right_speed = out_q.spd[0];
	assign front_left_speed  = out_q.spd[1];
	assign back_left_speed   = out_q.spd[2];
	assign back_right_speed  = out_q.spd[3];
	assign front_right_angle = out_q.ang[0];
	assign front_left_angle  = out_q.ang[1];
	assign back_left_angle   = out_q.ang[2];
	assign back_right_angle  = out_q.ang[3];

endmodule

// ===== sim/swdik_checker.sv =====
// checker: predicts swerve module speeds and angles and compares result beats
`timescale 1ns / 100ps
module swdik_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic [swdik_pkg::IDX_W-1:0] cfg_index,
	input  logic [swdik_pkg::CFG_W-1:0] cfg_data,
	input  logic in_valid,
	input  logic in_stall,
	input  logic signed [15:0] forward_cmd,
	input  logic signed [15:0] strafe_cmd,
	input  logic signed [15:0] rotate_cmd,
	input  logic [15:0] heading_angle,
	input  logic out_valid,
	input  logic out_stall,
	input  logic [14:0] front_right_speed,
	input  logic [14:0] front_left_speed,
	input  logic [14:0] back_left_speed,
	input  logic [14:0] back_right_speed,
	input  logic signed [15:0] front_right_angle,
	input  logic signed [15:0] front_left_angle,
	input  logic signed [15:0] back_left_angle,
	input  logic signed [15:0] back_right_angle,
	output int fail_count,
	output int pending
);
	import swdik_pkg::*;

	localparam int STAGES = 16;

	typedef struct packed {
		logic [3:0][14:0] spd;
		logic [3:0][15:0] ang;
	} wheels_t;

	longint arcs [24] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
		10430, 5215, 2608, 1304, 652, 326, 163, 81};

	longint base_len, track_len;
	wheels_t wheel_q [$];

	function automatic longint fshr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic void heading_trig(input logic [15:0] hd, output longint c,
			output longint s);
		longint z, x, y, dx, dy;
		logic [31:0] a;
		bit flip;
		a = {hd, 16'h0};
		flip = (hd[15:14] == 2'd1 || hd[15:14] == 2'd2);
		if (flip) a = a + 32'h8000_0000;
		z = longint'($signed(a));
		x = 652032874;
		y = 0;
		for (int i = 0; i < STAGES; i++) begin
			dx = fshr(y, i);
			dy = fshr(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= arcs[i];
			end else begin
				x += dx; y -= dy; z += arcs[i];
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic void vec_polar(input longint xi, input longint yi,
			output longint mag, output longint ang);
		longint x, y, z, t, dx, dy;
		x = xi; y = yi; z = 0;
		if (x == 0 && y == 0) begin
			mag = 0; ang = 0;
		end else begin
			if (x < 0) begin
				t = x;
				if (y >= 0) begin
					x = y; y = -t; z = 1073741824;
				end else begin
					x = -y; y = t; z = -1073741824;
				end
			end
			for (int i = 0; i < STAGES; i++) begin
				dx = fshr(y, i);
				dy = fshr(x, i);
				if (y > 0) begin
					x += dx; y -= dy; z += arcs[i];
				end else begin
					x -= dx; y += dy; z -= arcs[i];
				end
			end
			mag = fshr(x * 652032874 + (64'sd1 <<< 29), 30);
			if (mag < 0) mag = 0;
			ang = z;
		end
	endfunction

	function automatic wheels_t predict_wheels(longint vf, longint vs, longint vr,
			logic [15:0] hd);
		longint c, s, rf, rs, rl, rw, peak, sp;
		longint m [4], a [4];
		wheels_t w;
		heading_trig(hd, c, s);
		rf = fshr(vf * c + vs * s + 65536, 17);
		rs = fshr(vs * c - vf * s + 65536, 17);
		rl = vr * base_len;
		rw = vr * track_len;
		vec_polar(rf + rw, rs + rl, m[0], a[0]);
		vec_polar(rf - rw, rs + rl, m[1], a[1]);
		vec_polar(rf - rw, rs - rl, m[2], a[2]);
		vec_polar(rf + rw, rs - rl, m[3], a[3]);
		peak = m[0];
		for (int k = 1; k < 4; k++) if (m[k] > peak) peak = m[k];
		for (int k = 0; k < 4; k++) begin
			if (peak > 134217728) sp = ((m[k] <<< 14) + peak / 2) / peak;
			else sp = (m[k] + 4096) >>> 13;
			if (sp > 16384) sp = 16384;
			w.spd[k] = sp[14:0];
			w.ang[k] = 16'(fshr(a[k] + 32768, 16));
		end
		return w;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	assign pending = wheel_q.size();

	always @(posedge clk or negedge arst_n) begin
		wheels_t want, got;
		if (!arst_n) begin
			base_len <= longint'(BASE_LEN_RST);
			track_len <= longint'(TRACK_LEN_RST);
			fail_count = 0;
			wheel_q.delete();
		end else begin
			if (cfg_wr_en) begin
				if (cfg_index == REG_BASE_LEN) base_len <= longint'(cfg_data);
				else if (cfg_index == REG_TRACK_LEN) track_len <= longint'(cfg_data);
			end
			if (in_valid && !in_stall)
				wheel_q.push_back(predict_wheels(forward_cmd, strafe_cmd, rotate_cmd,
					heading_angle));
			if (out_valid && !out_stall) begin
				got.spd = {back_right_speed, back_left_speed, front_left_speed,
					front_right_speed};
				got.ang = {back_right_angle, back_left_angle, front_left_angle,
					front_right_angle};
				if (wheel_q.size() == 0) begin
					report_mismatch("unexpected beat", 1, 0);
				end else begin
					want = wheel_q.pop_front();
					for (int k = 0; k < 4; k++) begin
						if (got.spd[k] !== want.spd[k])
							report_mismatch($sformatf("speed%0d", k), got.spd[k], want.spd[k]);
						if (got.ang[k] !== want.ang[k])
							report_mismatch($sformatf("angle%0d", k),
								$signed(got.ang[k]), $signed(want.ang[k]));
					end
				end
			end
		end
	end
endmodule

// ===== sim/tb_top.sv =====
// testbench top: stimulus, idling phases and verdict for the kinematics block
`timescale 1ns / 100ps
module tb_top;
	import swdik_pkg::*;

	logic clk = 0, arst_n = 0;
	logic cfg_wr_en = 0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 0, in_stall, out_valid, out_stall = 0;
	logic signed [15:0] forward_cmd = 0, strafe_cmd = 0, rotate_cmd = 0;
	logic [15:0] heading_angle = 0;
	logic [14:0] fr_spd, fl_spd, bl_spd, br_spd;
	logic signed [15:0] fr_ang, fl_ang, bl_ang, br_ang;
	int fail_count, pending;
	int send_idle_pct = 0, stall_pct = 0;
	bit hold_off = 0;
	int quiet_cycles = 0;

	localparam int LATENCY = 59;
	localparam int QUIET_LIMIT = 20000;
	localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

	always #2 clk = ~clk;

	swerve_drive_inverse_kinematics dut (
		.clk, .arst_n, .cfg_wr_en, .cfg_index, .cfg_data,
		.in_valid, .in_stall, .forward_cmd, .strafe_cmd, .rotate_cmd, .heading_angle,
		.out_valid, .out_stall,
		.front_right_speed(fr_spd), .front_left_speed(fl_spd),
		.back_left_speed(bl_spd), .back_right_speed(br_spd),
		.front_right_angle(fr_ang), .front_left_angle(fl_ang),
		.back_left_angle(bl_ang), .back_right_angle(br_ang)
	);

	swdik_checker chk (
		.clk, .arst_n, .cfg_wr_en, .cfg_index, .cfg_data,
		.in_valid, .in_stall, .forward_cmd, .strafe_cmd, .rotate_cmd, .heading_angle,
		.out_valid, .out_stall,
		.front_right_speed(fr_spd), .front_left_speed(fl_spd),
		.back_left_speed(bl_spd), .back_right_speed(br_spd),
		.front_right_angle(fr_ang), .front_left_angle(fl_ang),
		.back_left_angle(bl_ang), .back_right_angle(br_ang),
		.fail_count, .pending
	);

	// receiver: random stall, or a long hold-off to back the pipeline up
	always @(posedge clk) begin
		if (hold_off) out_stall <= 1;
		else out_stall <= ($urandom_range(99) < stall_pct);
	end

	// watchdog: cycles with no beat on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// one command beat, with random idle cycles before it
	task automatic send_cmd(input logic [15:0] f, input logic [15:0] s,
			input logic [15:0] r, input logic [15:0] h);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		end
		in_valid <= 1;
		forward_cmd <= f;
		strafe_cmd <= s;
		rotate_cmd <= r;
		heading_angle <= h;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// stop sending and wait for every result
	task automatic drain;
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [15:0] val);
		cfg_wr_en <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 0;
		@(posedge clk);
	endtask

	// random field value biased towards extremes and zero
	function automatic logic [15:0] pick16;
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'($urandom_range(2000)) - 16'd1000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_cmds(input int n);
		for (int i = 0; i < n; i++) begin
			// mostly realistic commands, sometimes full range
			if ($urandom_range(3) == 0)
				send_cmd(pick16(), pick16(), pick16(), 16'($urandom));
			else
				send_cmd(16'($urandom_range(32767)) - 16'd16384,
					16'($urandom_range(32767)) - 16'd16384,
					16'($urandom_range(16383)) - 16'd8192, 16'($urandom));
		end
	endtask

	initial begin
		logic [15:0] edges [5] = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'hffff};
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: zero vector, pure rotation, axis headings, extremes
		send_cmd(16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_cmd(16'h4000, 16'h0000, 16'h0000, 16'h0000);
		send_cmd(16'h0000, 16'h4000, 16'h0000, 16'h0000);
		send_cmd(16'h0000, 16'h0000, 16'h4000, 16'h0000);
		send_cmd(16'h4000, 16'h0000, 16'h0000, 16'h4000);
		send_cmd(16'h4000, 16'h0000, 16'h0000, 16'h8000);
		send_cmd(16'h4000, 16'h0000, 16'h0000, 16'hc000);
		send_cmd(16'hc000, 16'h0000, 16'h0000, 16'h0000);
		send_cmd(16'hc000, 16'h0001, 16'h0000, 16'h0000);
		send_cmd(16'hc000, 16'hffff, 16'h0000, 16'h0000);
		send_cmd(16'h1000, 16'h1000, 16'h0000, 16'h2000);
		for (int i = 0; i < 5; i++)
			send_cmd(edges[i], edges[4 - i], edges[(i + 2) % 5], edges[(i + 1) % 5]);
		send_cmd(16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_cmd(16'h7fff, 16'h7fff, 16'h7fff, 16'hffff);
		drain();

		// register extremes, including an ignored index
		write_reg(REG_BASE_LEN, 16'hffff);
		write_reg(REG_TRACK_LEN, 16'h0000);
		write_reg(REG_UNUSED, 16'h1234);
		send_cmd(16'h7fff, 16'h8000, 16'h7fff, 16'h1234);
		send_cmd(16'h0000, 16'h0000, 16'h8000, 16'h0000);
		send_cmd(16'd100, 16'hff9c, 16'h7fff, 16'h9000);
		random_cmds(60);
		drain();

		write_reg(REG_BASE_LEN, 16'h0000);
		write_reg(REG_TRACK_LEN, 16'hffff);
		random_cmds(60);
		drain();

		// idling phases with random register settings
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 86; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 86; end
				default: begin send_idle_pct = 38; stall_pct = 38; end
			endcase
			write_reg(REG_BASE_LEN, 16'($urandom_range(8192)));
			write_reg(REG_TRACK_LEN, 16'($urandom));
			random_cmds(300);
			drain();
		end

		// long receiver hold-off while commands keep coming
		send_idle_pct = 0;
		stall_pct = 0;
		write_reg(REG_BASE_LEN, BASE_LEN_RST);
		write_reg(REG_TRACK_LEN, TRACK_LEN_RST);
		fork
			begin
				hold_off = 1;
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
			random_cmds(150);
		join
		drain();
		stall_pct = 20;
		send_idle_pct = 10;
		random_cmds(260);
		drain();

		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule

// ===== files.f =====
design/swdik_pkg.sv
design/swdik_sincos.sv
design/swdik_polar.sv
design/swdik_div.sv
design/swerve_drive_inverse_kinematics.sv
sim/swdik_checker.sv
sim/tb_top.sv
